// ===== design/sorted_leaf_entry_table_assert.svh =====
// Assertion macros used by the sorted leaf entry table checker.
// Depends on nothing; expects clk and rst_n in the scope of use.
`ifndef SORTED_LEAF_ENTRY_TABLE_ASSERT_SVH
`define SORTED_LEAF_ENTRY_TABLE_ASSERT_SVH

// same-cycle implication, off during reset
`define SLET_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("slet assertion failed");

// next-cycle implication, off during reset
`define SLET_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("slet assertion failed");

`endif

// ===== design/slet_pkg.sv =====
// Types and codes for the sorted leaf entry table.
// No dependencies.
package slet_pkg;

  localparam int FIELD_W = 32;
  localparam int SMALL_W = 7;

  typedef enum logic [1:0] {
    FN_INSERT   = 2'd0,
    FN_LOCATE   = 2'd1,
    FN_READ     = 2'd2,
    FN_SET_LINK = 2'd3
  } func_t;

  typedef enum logic [2:0] {
    ST_OK        = 3'd0,
    ST_FULL      = 3'd1,
    ST_NOT_FOUND = 3'd2,
    ST_BAD_POS   = 3'd3,
    ST_BAD_LINK  = 3'd4
  } status_t;

  typedef struct packed {
    logic signed [FIELD_W-1:0] key;
    logic signed [FIELD_W-1:0] page;
    logic signed [FIELD_W-1:0] slot;
  } entry_t;

  // what a cell tells the chain about itself
  typedef struct packed {
    logic gt;   // empty, or key above the probe: shifts on insert
    logic ge;   // holds a key at or above the probe
  } cell_flags_t;

endpackage

// ===== design/sorted_leaf_entry_table.sv =====
// Sorted leaf entry table (B+ tree leaf node) built as a chain of slot cells.
// Each result beat is registered and shows in the cycle after its input beat.
// Throughput: one beat per cycle while out_ready holds; the insert shift,
// locate compare and read select all happen across the cell row on accept.
// Reset: entry count 0, sibling link -1, no result pending; slot contents
// are left as they are and only read below the count.
module sorted_leaf_entry_table
  import slet_pkg::*;
#(
  parameter int CAPACITY = 64
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_valid,
  output logic                      in_ready,
  input  logic [1:0]                in_func,
  input  logic signed [FIELD_W-1:0] in_key,
  input  logic signed [FIELD_W-1:0] in_rec_page,
  input  logic signed [FIELD_W-1:0] in_rec_slot,
  input  logic [SMALL_W-1:0]        in_position,
  input  logic signed [FIELD_W-1:0] in_link_in,
  output logic                      out_valid,
  input  logic                      out_ready,
  output logic [2:0]                out_status,
  output logic [SMALL_W-1:0]        out_found_position,
  output logic signed [FIELD_W-1:0] out_key_out,
  output logic signed [FIELD_W-1:0] out_page_out,
  output logic signed [FIELD_W-1:0] out_slot_out,
  output logic [SMALL_W-1:0]        out_entry_count,
  output logic signed [FIELD_W-1:0] out_link_out
);

  localparam int CW = $clog2(CAPACITY + 1);

  // control state
  logic [CW-1:0]             count_r, count_nxt;
  logic signed [FIELD_W-1:0] link_r, link_nxt;
  logic                      out_valid_r;

  // result register (payload, no reset)
  status_t                   status_r, status_nxt;
  logic [CW-1:0]             found_r, found_nxt;
  entry_t                    rd_r, rd_nxt;

  logic    accept;
  func_t   func;
  logic    full;
  logic    ins_en;
  entry_t  new_entry;

  entry_t      cell_entry [CAPACITY];
  cell_flags_t cell_flags [CAPACITY];
  logic [CW-1:0] hit_pos  [CAPACITY];   // i+1 where slot i is the first hit
  entry_t        rd_part  [CAPACITY];   // entry where slot i is addressed

  logic [CW-1:0] hit_any;
  entry_t        rd_any;
  logic          pos_bad;

  // output register parts the two sides: take a beat whenever it is empty or drains
  assign accept   = in_valid && in_ready;
  assign in_ready = !out_valid_r || out_ready;
  assign func     = func_t'(in_func);
  assign full     = (count_r == CW'(CAPACITY));
  assign ins_en   = accept && (func == FN_INSERT) && !full;

  assign new_entry.key  = in_key;
  assign new_entry.page = in_rec_page;
  assign new_entry.slot = in_rec_slot;

  // slot row: an insert moves every slot above the insertion point up by one
  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic valid_i;
    assign valid_i = (CW'(i) < count_r);

    if (i == 0) begin : g_first
      slet_cell u_cell (
        .clk        (clk),
        .valid      (valid_i),
        .ins_en     (ins_en),
        .probe_key  (in_key),
        .new_entry  (new_entry),
        .left_entry (new_entry),
        .left_gt    (1'b0),
        .entry      (cell_entry[i]),
        .flags      (cell_flags[i])
      );
      assign hit_pos[i] = cell_flags[i].ge ? CW'(1) : '0;
    end else begin : g_rest
      slet_cell u_cell (
        .clk        (clk),
        .valid      (valid_i),
        .ins_en     (ins_en),
        .probe_key  (in_key),
        .new_entry  (new_entry),
        .left_entry (cell_entry[i-1]),
        .left_gt    (cell_flags[i-1].gt),
        .entry      (cell_entry[i]),
        .flags      (cell_flags[i])
      );
      // keys are sorted, so the ge flags form a thermometer: its edge is the hit
      assign hit_pos[i] = (cell_flags[i].ge && !cell_flags[i-1].ge) ? CW'(i + 1) : '0;
    end

    assign rd_part[i] = (valid_i && (32'(in_position) == 32'(i + 1))) ? cell_entry[i] : '0;
  end

  // at most one slot drives each of these, so an OR collects it
  always_comb begin
    hit_any = '0;
    rd_any  = '0;
    for (int i = 0; i < CAPACITY; i++) begin
      hit_any = hit_any | hit_pos[i];
      rd_any  = rd_any | rd_part[i];
    end
  end

  assign pos_bad = (in_position == '0) || (32'(in_position) > 32'(count_r));

  always_comb begin
    count_nxt  = count_r;
    link_nxt   = link_r;
    status_nxt = ST_OK;
    found_nxt  = '0;
    rd_nxt     = '0;
    case (func)
      FN_INSERT: begin
        if (full) begin
          status_nxt = ST_FULL;
        end else begin
          count_nxt = count_r + CW'(1);
        end
      end
      FN_LOCATE: begin
        found_nxt = hit_any;
        if (hit_any == '0) begin
          status_nxt = ST_NOT_FOUND;
        end
      end
      FN_READ: begin
        if (pos_bad) begin
          status_nxt = ST_BAD_POS;
        end else begin
          rd_nxt = rd_any;
        end
      end
      FN_SET_LINK: begin
        if (in_link_in < -32'sd1) begin
          status_nxt = ST_BAD_LINK;
        end else begin
          link_nxt = in_link_in;
        end
      end
      default: begin
        status_nxt = ST_OK;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      link_r      <= -32'sd1;
      out_valid_r <= 1'b0;
    end else begin
      if (accept) begin
        count_r     <= count_nxt;
        link_r      <= link_nxt;
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      status_r <= status_nxt;
      found_r  <= found_nxt;
      rd_r     <= rd_nxt;
    end
  end

  // link and count are reported as they stand after the beat
  assign out_valid          = out_valid_r;
  assign out_status         = status_r;
  assign out_found_position = SMALL_W'(found_r);
  assign out_key_out        = rd_r.key;
  assign out_page_out       = rd_r.page;
  assign out_slot_out       = rd_r.slot;
  assign out_entry_count    = SMALL_W'(count_r);
  assign out_link_out       = link_r;

endmodule

// ===== design/slet_cell.sv =====
// One slot of the leaf table: holds an entry, compares it with the probe key.
// Depends on slet_pkg.
module slet_cell
  import slet_pkg::*;
(
  input  logic                      clk,
  input  logic                      valid,      // slot lies below the entry count
  input  logic                      ins_en,     // insert beat accepted
  input  logic signed [FIELD_W-1:0] probe_key,
  input  entry_t                    new_entry,
  input  entry_t                    left_entry,
  input  logic                      left_gt,    // tied low for the first slot
  output entry_t                    entry,
  output cell_flags_t               flags
);

  entry_t entry_r;
  entry_t entry_nxt;

  always_comb begin
    flags.gt = !valid || (entry_r.key > probe_key);
    flags.ge = valid && (entry_r.key >= probe_key);
  end

  always_comb begin
    entry_nxt = entry_r;
    if (ins_en && flags.gt) begin
      entry_nxt = left_gt ? left_entry : new_entry;
    end
  end

  always_ff @(posedge clk) begin
    entry_r <= entry_nxt;
  end

  assign entry = entry_r;

endmodule

// ===== design/slet_checker.sv =====
// Port-level checker for the sorted leaf entry table, bound to the top level.
// Depends on slet_pkg and sorted_leaf_entry_table_assert.svh.
`include "sorted_leaf_entry_table_assert.svh"

module slet_checker
  import slet_pkg::*;
#(
  parameter int CAPACITY = 64
) (
  input logic                      clk,
  input logic                      rst_n,
  input logic                      in_valid,
  input logic                      in_ready,
  input logic                      out_valid,
  input logic                      out_ready,
  input logic [2:0]                out_status,
  input logic [SMALL_W-1:0]        out_found_position,
  input logic signed [FIELD_W-1:0] out_key_out,
  input logic signed [FIELD_W-1:0] out_page_out,
  input logic signed [FIELD_W-1:0] out_slot_out,
  input logic [SMALL_W-1:0]        out_entry_count,
  input logic signed [FIELD_W-1:0] out_link_out
);

  localparam int BEAT_W = 3 + 2 * SMALL_W + 4 * FIELD_W;

  // whole result payload, for the hold check
  logic [BEAT_W-1:0] out_beat;

  assign out_beat = {out_status, out_found_position, out_key_out, out_page_out,
                     out_slot_out, out_entry_count, out_link_out};

  // an accepted beat always shows a result beat next cycle
  `SLET_ASSERT_NEXT(a_beat_answers, in_valid && in_ready, out_valid)

  // a stalled result beat holds its payload
  `SLET_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_beat))

  // a located position lies within the table and comes with status ok
  `SLET_ASSERT_NOW(a_found_in_range, out_valid && (out_found_position != '0), (out_status == ST_OK) && (out_found_position <= out_entry_count))

  // the stored link never drops below the no-sibling value
  `SLET_ASSERT_NOW(a_link_floor, out_valid, out_link_out >= -32'sd1)

  // the entry count never exceeds the table size
  `SLET_ASSERT_NOW(a_count_cap, out_valid, 32'(out_entry_count) <= CAPACITY)

endmodule

bind sorted_leaf_entry_table slet_checker #(.CAPACITY(CAPACITY)) u_slet_checker (.*);

// ===== sim/sorted_leaf_entry_table_test.sv =====
// Self-checking bench for the sorted leaf entry table: directed then random beats.
// Depends on slet_pkg and the sorted_leaf_entry_table RTL; reads no files.
module sorted_leaf_entry_table_test;
  timeunit 1ns;
  timeprecision 1ps;
  import slet_pkg::*;

  localparam int CAPACITY        = 64;
  localparam int RANDOM_BEATS    = 848;
  localparam int PHASES          = 8;
  localparam int HOLD_OFF_CYCLES = 48;
  localparam int WATCHDOG_LIMIT  = 4000;
  localparam logic signed [FIELD_W-1:0] KEY_MIN = 32'sh8000_0000;
  localparam logic signed [FIELD_W-1:0] KEY_MAX = 32'sh7FFF_FFFF;

  // one input beat as the block sees it
  typedef struct {
    func_t                     func;
    logic signed [FIELD_W-1:0] key;
    logic signed [FIELD_W-1:0] page;
    logic signed [FIELD_W-1:0] slot;
    logic [SMALL_W-1:0]        position;
    logic signed [FIELD_W-1:0] link;
  } leaf_op_t;

  // one result beat; status kept as raw bits so odd codes still compare
  typedef struct {
    logic [2:0]                status;
    logic [SMALL_W-1:0]        found;
    logic signed [FIELD_W-1:0] key;
    logic signed [FIELD_W-1:0] page;
    logic signed [FIELD_W-1:0] slot;
    logic [SMALL_W-1:0]        count;
    logic signed [FIELD_W-1:0] link;
  } leaf_result_t;

  // Keeps its own copy of the leaf: entries in key order, count and sibling
  // link. Every accepted input beat yields exactly one awaited result.
  class leaf_table_scoreboard;
    logic signed [FIELD_W-1:0] keys  [CAPACITY];
    logic signed [FIELD_W-1:0] pages [CAPACITY];
    logic signed [FIELD_W-1:0] slots [CAPACITY];
    int unsigned               entries;
    logic signed [FIELD_W-1:0] next_link;
    leaf_result_t              awaited [$];
    int unsigned               mismatches;

    function new();
      entries    = 0;
      next_link  = -1;
      mismatches = 0;
    endfunction

    function int unsigned pending();
      return awaited.size();
    endfunction

    function void note_beat(leaf_op_t op);
      leaf_result_t r;
      int           at;
      r.status = ST_OK;
      r.found  = '0;
      r.key    = '0;
      r.page   = '0;
      r.slot   = '0;
      case (op.func)
        FN_INSERT: begin
          if (entries >= CAPACITY) begin
            r.status = ST_FULL;
          end else begin
            // new entry lands after every key less than or equal to its own
            at = int'(entries);
            for (int i = 0; i < int'(entries); i++) begin
              if (keys[i] > op.key) begin
                at = i;
                break;
              end
            end
            for (int i = int'(entries); i > at; i--) begin
              keys[i]  = keys[i-1];
              pages[i] = pages[i-1];
              slots[i] = slots[i-1];
            end
            keys[at]  = op.key;
            pages[at] = op.page;
            slots[at] = op.slot;
            entries++;
          end
        end
        FN_LOCATE: begin
          r.status = ST_NOT_FOUND;
          for (int i = 0; i < int'(entries); i++) begin
            if (keys[i] >= op.key) begin
              r.status = ST_OK;
              r.found  = SMALL_W'(i + 1);
              break;
            end
          end
        end
        FN_READ: begin
          if (op.position == 0 || op.position > entries) begin
            r.status = ST_BAD_POS;
          end else begin
            r.key  = keys[op.position - 1];
            r.page = pages[op.position - 1];
            r.slot = slots[op.position - 1];
          end
        end
        default: begin
          if (op.link < -1) r.status = ST_BAD_LINK;
          else next_link = op.link;
        end
      endcase
      r.count = SMALL_W'(entries);
      r.link  = next_link;
      awaited.push_back(r);
    endfunction

    function void field_ok(string name, logic signed [63:0] want, logic signed [63:0] seen);
      if (seen !== want) begin
        $error("%s mismatch: expected %0d, actual %0d", name, want, seen);
        mismatches++;
      end
    endfunction

    function void check_beat(leaf_result_t got);
      leaf_result_t want;
      if (awaited.size() == 0) begin
        $error("result beat with nothing awaited (status %0d)", got.status);
        mismatches++;
        return;
      end
      want = awaited.pop_front();
      field_ok("status", want.status, got.status);
      field_ok("found_position", want.found, got.found);
      field_ok("key_out", want.key, got.key);
      field_ok("page_out", want.page, got.page);
      field_ok("slot_out", want.slot, got.slot);
      field_ok("entry_count", want.count, got.count);
      field_ok("link_out", want.link, got.link);
    endfunction
  endclass

  logic                      clk         = 1'b0;
  logic                      rst_n       = 1'b0;
  logic                      in_valid    = 1'b0;
  logic                      in_ready;
  logic [1:0]                in_func     = '0;
  logic signed [FIELD_W-1:0] in_key      = '0;
  logic signed [FIELD_W-1:0] in_rec_page = '0;
  logic signed [FIELD_W-1:0] in_rec_slot = '0;
  logic [SMALL_W-1:0]        in_position = '0;
  logic signed [FIELD_W-1:0] in_link_in  = '0;
  logic                      out_valid;
  logic                      out_ready   = 1'b0;
  logic [2:0]                out_status;
  logic [SMALL_W-1:0]        out_found_position;
  logic signed [FIELD_W-1:0] out_key_out;
  logic signed [FIELD_W-1:0] out_page_out;
  logic signed [FIELD_W-1:0] out_slot_out;
  logic [SMALL_W-1:0]        out_entry_count;
  logic signed [FIELD_W-1:0] out_link_out;

  leaf_table_scoreboard sb;

  // idling controls: percentages are changed only at a rising edge, the
  // receiver reads them at the falling edge
  int unsigned send_idle_pct = 0;
  int unsigned stall_pct     = 0;
  bit          hold_req      = 1'b0;
  int unsigned hold_left     = 0;

  sorted_leaf_entry_table #(.CAPACITY(CAPACITY)) DUT (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_ready           (in_ready),
    .in_func            (in_func),
    .in_key             (in_key),
    .in_rec_page        (in_rec_page),
    .in_rec_slot        (in_rec_slot),
    .in_position        (in_position),
    .in_link_in         (in_link_in),
    .out_valid          (out_valid),
    .out_ready          (out_ready),
    .out_status         (out_status),
    .out_found_position (out_found_position),
    .out_key_out        (out_key_out),
    .out_page_out       (out_page_out),
    .out_slot_out       (out_slot_out),
    .out_entry_count    (out_entry_count),
    .out_link_out       (out_link_out)
  );

  always #10 clk = ~clk;

  // Receiver: random stalls, plus a long hold-off on request. The hold-off
  // is counted here so the sender keeps offering beats meanwhile and the
  // block has to back-pressure its input.
  always @(negedge clk) begin
    if (hold_req) begin
      hold_left = HOLD_OFF_CYCLES;
      hold_req  = 1'b0;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(99) >= stall_pct);
    end
  end

  // Monitor: input beat noted before the result beat of the same edge, so an
  // answer in the same cycle would still find its expectation waiting.
  always @(posedge clk) begin : monitor
    leaf_op_t     op;
    leaf_result_t res;
    if (rst_n) begin
      if (in_valid && in_ready) begin
        op.func     = func_t'(in_func);
        op.key      = in_key;
        op.page     = in_rec_page;
        op.slot     = in_rec_slot;
        op.position = in_position;
        op.link     = in_link_in;
        sb.note_beat(op);
      end
      if (out_valid && out_ready) begin
        res.status = out_status;
        res.found  = out_found_position;
        res.key    = out_key_out;
        res.page   = out_page_out;
        res.slot   = out_slot_out;
        res.count  = out_entry_count;
        res.link   = out_link_out;
        sb.check_beat(res);
      end
    end
  end

  // Watchdog: too long without any beat on either side ends the run.
  initial begin : watchdog
    int unsigned quiet;
    quiet = 0;
    while (quiet < WATCHDOG_LIMIT) begin
      @(posedge clk);
      if ((in_valid && in_ready) || (out_valid && out_ready)) quiet = 0;
      else quiet++;
    end
    $display("sorted_leaf_entry_table verification failed");
    $finish;
  end

  // Drive one beat from a falling edge, with random idle cycles first; valid
  // stays high and the payload still until the beat is taken.
  task automatic send_beat(leaf_op_t op);
    @(negedge clk);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid    <= 1'b1;
    in_func     <= op.func;
    in_key      <= op.key;
    in_rec_page <= op.page;
    in_rec_slot <= op.slot;
    in_position <= op.position;
    in_link_in  <= op.link;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  task automatic issue(input func_t f, input logic signed [FIELD_W-1:0] k, p, s,
                       input logic [SMALL_W-1:0] pos, input logic signed [FIELD_W-1:0] l);
    leaf_op_t op;
    op.func     = f;
    op.key      = k;
    op.page     = p;
    op.slot     = s;
    op.position = pos;
    op.link     = l;
    send_beat(op);
  endtask

  // stop offering and wait for every awaited result to come back
  task automatic drain();
    @(negedge clk);
    in_valid <= 1'b0;
    while (sb.pending() != 0) @(negedge clk);
  endtask

  task automatic start_phase(int unsigned idle, int unsigned stall, bit hold);
    @(posedge clk);
    send_idle_pct = idle;
    stall_pct     = stall;
    if (hold) hold_req = 1'b1;
  endtask

  // keys: mostly small values and keys already held, so duplicates and
  // exact locate hits are common; some extremes and full-width noise
  function automatic logic signed [FIELD_W-1:0] pick_key();
    int unsigned r;
    r = $urandom_range(99);
    if (r < 30 && sb.entries > 0) return sb.keys[$urandom_range(sb.entries - 1)];
    if (r < 60) return FIELD_W'(int'($urandom_range(16)) - 8);
    if (r < 70) begin
      case ($urandom_range(3))
        0:       return KEY_MIN;
        1:       return KEY_MAX;
        2:       return -1;
        default: return 0;
      endcase
    end
    return $urandom;
  endfunction

  // positions: mostly around the live range, else anything the port carries
  function automatic logic [SMALL_W-1:0] pick_position();
    if ($urandom_range(99) < 65) return SMALL_W'($urandom_range(sb.entries + 1));
    return SMALL_W'($urandom_range(127));
  endfunction

  function automatic logic signed [FIELD_W-1:0] pick_link();
    int unsigned r;
    r = $urandom_range(99);
    if (r < 25) return -1;
    if (r < 50) return $urandom_range(1000);
    if (r < 75) return $urandom | 32'h8000_0000;
    return $urandom;
  endfunction

  // Inserts kept rare so the table fills part way through the run: locate
  // and read see many fill levels, then the full table gets its share.
  task automatic send_random();
    leaf_op_t    op;
    int unsigned r;
    r = $urandom_range(99);
    if (r < 15)      op.func = FN_INSERT;
    else if (r < 50) op.func = FN_LOCATE;
    else if (r < 85) op.func = FN_READ;
    else             op.func = FN_SET_LINK;
    op.key      = pick_key();
    op.page     = $urandom;
    op.slot     = $urandom;
    op.position = pick_position();
    op.link     = pick_link();
    send_beat(op);
  endtask

  initial begin
    sb = new();
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // empty table: reads rejected, locate finds nothing
    issue(FN_READ, 0, 0, 0, 1, 0);
    issue(FN_READ, 0, 0, 0, 0, 0);
    issue(FN_LOCATE, 0, 0, 0, 0, 0);
    // sibling link: minus one accepted, anything below refused
    issue(FN_SET_LINK, 0, 0, 0, 0, -1);
    issue(FN_SET_LINK, 0, 0, 0, 0, -2);
    issue(FN_SET_LINK, 0, 0, 0, 0, KEY_MIN);
    issue(FN_SET_LINK, 0, 0, 0, 0, KEY_MAX);
    issue(FN_SET_LINK, 0, 0, 0, 0, 0);
    // equal keys: the later one goes behind
    issue(FN_INSERT, 5, KEY_MIN, KEY_MAX, 0, 0);
    issue(FN_INSERT, 5, 1, 2, 0, 0);
    issue(FN_INSERT, KEY_MIN, -1, 0, 0, 0);
    // non-empty table: locate past the largest key, then an exact hit
    issue(FN_LOCATE, 100, 0, 0, 0, 0);
    issue(FN_LOCATE, 5, 0, 0, 0, 0);
    issue(FN_INSERT, KEY_MAX, KEY_MAX, KEY_MIN, 0, 0);
    issue(FN_INSERT, -1, 7, 7, 0, 0);
    issue(FN_LOCATE, KEY_MIN, 0, 0, 0, 0);
    issue(FN_LOCATE, KEY_MAX, 0, 0, 0, 0);
    issue(FN_LOCATE, 6, 0, 0, 0, 0);
    issue(FN_LOCATE, -1, 0, 0, 0, 0);
    // reads at both ends of the table and past it
    issue(FN_READ, 0, 0, 0, 1, 0);
    issue(FN_READ, 0, 0, 0, 3, 0);
    issue(FN_READ, 0, 0, 0, 5, 0);
    issue(FN_READ, 0, 0, 0, 6, 0);
    issue(FN_READ, 0, 0, 0, 64, 0);
    issue(FN_READ, 0, 0, 0, 127, 0);
    drain();

    // random phases; each ends with the sender waiting for the results
    for (int p = 0; p < PHASES; p++) begin
      case (p % 4)
        0:       start_phase(0, 0, 1'b1);
        1:       start_phase(65, 0, 1'b0);
        2:       start_phase(0, 65, 1'b0);
        default: start_phase(27, 27, 1'b0);
      endcase
      repeat (RANDOM_BEATS / PHASES) send_random();
      drain();
    end

    repeat (4) @(posedge clk);
    if (sb.mismatches == 0 && sb.pending() == 0) begin
      $display("sorted_leaf_entry_table verification clean");
    end else begin
      $display("sorted_leaf_entry_table verification failed");
    end
    $finish;
  end

endmodule
